### sv/gsk_pkg.sv
// ----------------------------------------------------------------------------
// gsk_pkg
// shared widths, register codes and pipeline bundles of the pair kernel
// ----------------------------------------------------------------------------
package gsk_pkg;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam int REG_W      = 32;
    localparam int MASS_W     = 32;
    localparam int METER_W    = 62;
    localparam int SQ_W       = 2 * METER_W;
    localparam int Q_W        = SQ_W + 2;
    localparam int S_W        = Q_W + 1;
    localparam int ROOT_W     = 63;
    localparam int UNIT_W     = 33;
    localparam int UNIT_SHIFT = 32;
    localparam int GM_W       = 64;
    localparam int NUM_W      = GM_W + UNIT_W;
    localparam int OUT_W      = 48;
    localparam int OUT_DATA_W = 6 * OUT_W;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_GAIN  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOFTENING   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_METER_SCALE = 2'd2;

    localparam logic [REG_W-1:0] FORCE_GAIN_RST  = 32'd1;
    localparam logic [REG_W-1:0] SOFTENING_RST   = 32'd0;
    localparam logic [REG_W-1:0] METER_SCALE_RST = 32'd65536;

    localparam logic [METER_W-1:0] METER_MAX = '1;
    localparam logic [OUT_W-1:0]   POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0]   NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]        neg;
        logic              same;
        logic [MASS_W-1:0] lmass;
        logic [MASS_W-1:0] rmass;
        logic              upd_l;
        logic              upd_r;
    } ctl_t;

    typedef struct packed {
        ctl_t                         ctl;
        logic [2:0][METER_W-1:0]      meter;
        logic [S_W-1:0]               s;
    } sq_bundle_t;

    typedef struct packed {
        ctl_t           ctl;
        logic [S_W-1:0] s;
        logic           dz;
    } ud_bundle_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       same;
        logic       upd_l;
        logic       upd_r;
        logic [5:0] ovf;
        logic       sz;
    } fd_bundle_t;

endpackage

### sv/gsk_sqrt.sv
// ----------------------------------------------------------------------------
// gsk_sqrt
// pipelined integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
module gsk_sqrt #(
    parameter int IN_W   = gsk_pkg::Q_W,
    parameter int ROOT_W = gsk_pkg::ROOT_W
) (
    input  logic              clk,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand,
    output logic [ROOT_W-1:0] root
);

    localparam int CW = (IN_W > 2 * ROOT_W + 1) ? IN_W : 2 * ROOT_W + 1;

    logic [IN_W-1:0]   rem_reg [ROOT_W];
    logic [ROOT_W-1:0] res_reg [ROOT_W];

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++)
        begin : g_stage
            localparam int B = ROOT_W - 1 - i;
            logic [IN_W-1:0]   rem_in;
            logic [ROOT_W-1:0] res_in;
            logic [CW-1:0]     trial;
            logic [CW:0]       diff;

            if (i == 0)
            begin : g_first
                assign rem_in = radicand;
                assign res_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign res_in = res_reg[i-1];
            end

            assign trial = (CW'(res_in) << (B + 1)) | (CW'(1) << (2 * B));
            assign diff  = {1'b0, CW'(rem_in)} - {1'b0, trial};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= diff[CW] ? rem_in : diff[IN_W-1:0];
                    res_reg[i] <= diff[CW] ? res_in : (res_in | (ROOT_W'(1) << B));
                end
            end
        end
    endgenerate

    assign root = res_reg[ROOT_W-1];

endmodule

### sv/gsk_div.sv
// ----------------------------------------------------------------------------
// gsk_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module gsk_div #(
    parameter int NUM_W = gsk_pkg::NUM_W,
    parameter int DEN_W = gsk_pkg::S_W,
    parameter int QUO_W = gsk_pkg::OUT_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    genvar i;
    generate
        for (i = 0; i < QUO_W; i++)
        begin : g_stage
            localparam int J = QUO_W - 1 - i;
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [QUO_W-1:0] quo_in;
            logic [CW:0]      diff;

            if (i == 0)
            begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign den_in = den_reg[i-1];
                assign quo_in = quo_reg[i-1];
            end

            assign diff = {1'b0, CW'(rem_in)} - ({1'b0, CW'(den_in)} << J);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= diff[CW] ? rem_in : diff[NUM_W-1:0];
                    den_reg[i] <= den_in;
                    quo_reg[i] <= quo_in | (QUO_W'(!diff[CW]) << J);
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_W-1];

endmodule

### sv/softened_gravity_pair_kernel.sv
// ----------------------------------------------------------------------------
// softened_gravity_pair_kernel
// velocity increments of two bodies from their mutual softened gravity
// ----------------------------------------------------------------------------
// Takes one body pair per clock while the output side is ready and returns one
// word per pair, in order, through the distance, meter, partial square, square
// and sum stages, 63 stages of square root, 33 stages of unit vector division, 3
// multiply stages and 48 stages of force division, then the output register.
// The whole pipeline advances whenever the output register is empty or taken,
// so with the output side ready the rate is one pair per cycle. Configuration
// registers are used live and must be written only while the pipeline is empty.
// ----------------------------------------------------------------------------
module softened_gravity_pair_kernel #(
    parameter int POSITION_WIDTH = gsk_pkg::POSITION_WIDTH_DEF,
    parameter int FRACTION_BITS  = gsk_pkg::FRACTION_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [gsk_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [gsk_pkg::REG_W-1:0]                  cfg_data,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // left_x, left_y, left_z, right_x, right_y, right_z, left_mass, right_mass
    input  logic [((6*POSITION_WIDTH+64+7)/8)*8-1:0]   s_axis_tdata,
    // update_left, update_right
    input  logic [1:0]                                 s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // left_dvx, left_dvy, left_dvz, right_dvx, right_dvy, right_dvz
    output logic [gsk_pkg::OUT_DATA_W-1:0]             m_axis_tdata,
    // coincident, saturated
    output logic [1:0]                                 m_axis_tuser
);

    localparam int PW     = POSITION_WIDTH;
    localparam int PRW    = PW + gsk_pkg::REG_W;
    localparam int MXW    = PRW + gsk_pkg::METER_W;
    localparam int E_RAW  = 3 * FRACTION_BITS - 64;
    localparam int E_POS  = (E_RAW > 0) ? E_RAW : 0;
    localparam int E_NEG  = (E_RAW < 0) ? -E_RAW : 0;
    localparam int FN_W   = gsk_pkg::NUM_W + E_POS;
    localparam int FD_W   = gsk_pkg::S_W + E_NEG;
    localparam int XW     = (FN_W > FD_W) ? FN_W : FD_W;
    localparam int SQ_N   = gsk_pkg::ROOT_W;
    localparam int UD_N   = gsk_pkg::UNIT_W;
    localparam int FD_N   = gsk_pkg::OUT_W;
    localparam int TOTAL  = 5 + SQ_N + UD_N + 3 + FD_N + 1;

    localparam int MW  = gsk_pkg::METER_W;
    localparam int OW  = gsk_pkg::OUT_W;
    localparam int SW  = gsk_pkg::S_W;

    // configuration
    logic [gsk_pkg::REG_W-1:0] gain_reg;
    logic [gsk_pkg::REG_W-1:0] soft_reg;
    logic [gsk_pkg::REG_W-1:0] scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= gsk_pkg::FORCE_GAIN_RST;
            soft_reg  <= gsk_pkg::SOFTENING_RST;
            scale_reg <= gsk_pkg::METER_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gsk_pkg::CFG_FORCE_GAIN:  gain_reg  <= cfg_data;
                gsk_pkg::CFG_SOFTENING:   soft_reg  <= cfg_data;
                gsk_pkg::CFG_METER_SCALE: scale_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // pipeline control
    logic [TOTAL-1:0] vld_reg;
    logic             adv;

    assign adv           = !vld_reg[TOTAL-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[TOTAL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], s_axis_tvalid};
        end
    end

    // stage 1: axis distances
    logic [2:0][PW-1:0]   a_next;
    gsk_pkg::ctl_t        ctl1_next;
    logic [2:0][PW-1:0]   a_reg;
    gsk_pkg::ctl_t        ctl1_reg;

    always_comb
    begin
        logic [PW-1:0] pl;
        logic [PW-1:0] pr;
        logic [PW:0]   diff;
        logic [PW:0]   ndiff;
        ctl1_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            pl    = s_axis_tdata[c*PW +: PW];
            pr    = s_axis_tdata[(3+c)*PW +: PW];
            diff  = {pl[PW-1], pl} - {pr[PW-1], pr};
            ndiff = (PW+1)'(0) - diff;
            ctl1_next.neg[c] = diff[PW];
            a_next[c] = diff[PW] ? ndiff[PW-1:0] : diff[PW-1:0];
        end
        ctl1_next.same  = (a_next == '0);
        ctl1_next.lmass = s_axis_tdata[6*PW +: gsk_pkg::MASS_W];
        ctl1_next.rmass = s_axis_tdata[6*PW+gsk_pkg::MASS_W +: gsk_pkg::MASS_W];
        ctl1_next.upd_l = s_axis_tuser[0];
        ctl1_next.upd_r = s_axis_tuser[1];
    end

    // stage 2: meters
    logic [2:0][MW-1:0] meter2_next;
    logic [2:0][MW-1:0] meter2_reg;
    gsk_pkg::ctl_t      ctl2_reg;

    always_comb
    begin
        logic [PRW-1:0] prod;
        logic [MXW-1:0] shifted;
        for (int c = 0; c < 3; c++)
        begin
            prod    = PRW'(a_reg[c]) * PRW'(scale_reg);
            shifted = MXW'(prod) >> FRACTION_BITS;
            meter2_next[c] = (shifted > MXW'(gsk_pkg::METER_MAX)) ?
                             gsk_pkg::METER_MAX : shifted[MW-1:0];
        end
    end

    // stage 3: partial squares
    localparam int HW = MW / 2;
    logic [2:0][MW-1:0] hh_reg;
    logic [2:0][MW-1:0] hl_reg;
    logic [2:0][MW-1:0] ll_reg;
    logic [2:0][MW-1:0] meter3_reg;
    gsk_pkg::ctl_t      ctl3_reg;

    // stage 4: squares
    logic [2:0][gsk_pkg::SQ_W-1:0] sq_reg;
    logic [2:0][MW-1:0]            meter4_reg;
    gsk_pkg::ctl_t                 ctl4_reg;

    // stage 5: sum of squares and softened sum
    logic [gsk_pkg::Q_W-1:0] q_next;
    logic [SW-1:0]           s_next;
    logic [gsk_pkg::Q_W-1:0] q_reg;
    logic [SW-1:0]           s5_reg;
    logic [2:0][MW-1:0]      meter5_reg;
    gsk_pkg::ctl_t           ctl5_reg;

    assign q_next = gsk_pkg::Q_W'(sq_reg[0]) + gsk_pkg::Q_W'(sq_reg[1])
                  + gsk_pkg::Q_W'(sq_reg[2]);
    assign s_next = SW'(q_next) + (SW'(soft_reg) << FRACTION_BITS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg    <= a_next;
            ctl1_reg <= ctl1_next;

            meter2_reg <= meter2_next;
            ctl2_reg   <= ctl1_reg;

            for (int c = 0; c < 3; c++)
            begin
                hh_reg[c] <= MW'(meter2_reg[c][MW-1:HW]) * MW'(meter2_reg[c][MW-1:HW]);
                hl_reg[c] <= MW'(meter2_reg[c][MW-1:HW]) * MW'(meter2_reg[c][HW-1:0]);
                ll_reg[c] <= MW'(meter2_reg[c][HW-1:0]) * MW'(meter2_reg[c][HW-1:0]);
            end
            meter3_reg <= meter2_reg;
            ctl3_reg   <= ctl2_reg;

            for (int c = 0; c < 3; c++)
            begin
                sq_reg[c] <= (gsk_pkg::SQ_W'(hh_reg[c]) << (2 * HW))
                           + (gsk_pkg::SQ_W'(hl_reg[c]) << (HW + 1))
                           + gsk_pkg::SQ_W'(ll_reg[c]);
            end
            meter4_reg <= meter3_reg;
            ctl4_reg   <= ctl3_reg;

            q_reg      <= q_next;
            s5_reg     <= s_next;
            meter5_reg <= meter4_reg;
            ctl5_reg   <= ctl4_reg;
        end
    end

    // square root and its side delay
    logic [gsk_pkg::ROOT_W-1:0] root;
    gsk_pkg::sq_bundle_t        sqd_reg [SQ_N];

    gsk_sqrt #(
        .IN_W   (gsk_pkg::Q_W),
        .ROOT_W (gsk_pkg::ROOT_W)
    ) u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (q_reg),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqd_reg[0].ctl   <= ctl5_reg;
            sqd_reg[0].meter <= meter5_reg;
            sqd_reg[0].s     <= s5_reg;
            for (int k = 1; k < SQ_N; k++)
            begin
                sqd_reg[k] <= sqd_reg[k-1];
            end
        end
    end

    // unit vector division and its side delay
    logic [2:0][UD_N-1:0] uquo;
    gsk_pkg::ud_bundle_t  udd_reg [UD_N];

    genvar gc;
    generate
        for (gc = 0; gc < 3; gc++)
        begin : g_unit
            gsk_div #(
                .NUM_W (MW + gsk_pkg::UNIT_SHIFT),
                .DEN_W (gsk_pkg::ROOT_W),
                .QUO_W (UD_N)
            ) u_div (
                .clk (clk),
                .en  (adv),
                .num ({sqd_reg[SQ_N-1].meter[gc], {gsk_pkg::UNIT_SHIFT{1'b0}}}),
                .den (root),
                .quo (uquo[gc])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            udd_reg[0].ctl <= sqd_reg[SQ_N-1].ctl;
            udd_reg[0].s   <= sqd_reg[SQ_N-1].s;
            udd_reg[0].dz  <= (root == '0);
            for (int k = 1; k < UD_N; k++)
            begin
                udd_reg[k] <= udd_reg[k-1];
            end
        end
    end

    // force numerator
    logic [2:0][UD_N-1:0]           u_reg;
    logic [1:0][gsk_pkg::GM_W-1:0]  gm_reg;
    gsk_pkg::ctl_t                  ctlb1_reg;
    logic [SW-1:0]                  sb1_reg;
    logic [5:0][UD_N+31:0]          phi_reg;
    logic [5:0][UD_N+31:0]          plo_reg;
    gsk_pkg::ctl_t                  ctlb2_reg;
    logic [SW-1:0]                  sb2_reg;
    logic [5:0][gsk_pkg::NUM_W-1:0] num_reg;
    gsk_pkg::ctl_t                  ctlb3_reg;
    logic [SW-1:0]                  sb3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                u_reg[c] <= udd_reg[UD_N-1].dz ? '0 : uquo[c];
            end
            gm_reg[0] <= gsk_pkg::GM_W'(gain_reg) * gsk_pkg::GM_W'(udd_reg[UD_N-1].ctl.rmass);
            gm_reg[1] <= gsk_pkg::GM_W'(gain_reg) * gsk_pkg::GM_W'(udd_reg[UD_N-1].ctl.lmass);
            ctlb1_reg <= udd_reg[UD_N-1].ctl;
            sb1_reg   <= udd_reg[UD_N-1].s;

            for (int sd = 0; sd < 2; sd++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    phi_reg[sd*3+c] <= (UD_N+32)'(gm_reg[sd][63:32]) * (UD_N+32)'(u_reg[c]);
                    plo_reg[sd*3+c] <= (UD_N+32)'(gm_reg[sd][31:0]) * (UD_N+32)'(u_reg[c]);
                end
            end
            ctlb2_reg <= ctlb1_reg;
            sb2_reg   <= sb1_reg;

            for (int k = 0; k < 6; k++)
            begin
                num_reg[k] <= (gsk_pkg::NUM_W'(phi_reg[k]) << 32)
                            + gsk_pkg::NUM_W'(plo_reg[k]);
            end
            ctlb3_reg <= ctlb2_reg;
            sb3_reg   <= sb2_reg;
        end
    end

    // force division
    logic [FD_W-1:0]      fden;
    logic [5:0]           ovf;
    logic [5:0][OW-1:0]   fquo;
    gsk_pkg::fd_bundle_t  fdd_reg [FD_N];

    assign fden = FD_W'(sb3_reg) << E_NEG;

    generate
        for (gc = 0; gc < 6; gc++)
        begin : g_force
            logic [FN_W-1:0] fnum;
            assign fnum    = FN_W'(num_reg[gc]) << E_POS;
            assign ovf[gc] = (XW'(fnum) >> OW) >= XW'(fden);

            gsk_div #(
                .NUM_W (FN_W),
                .DEN_W (FD_W),
                .QUO_W (OW)
            ) u_div (
                .clk (clk),
                .en  (adv),
                .num (fnum),
                .den (fden),
                .quo (fquo[gc])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fdd_reg[0].neg   <= ctlb3_reg.neg;
            fdd_reg[0].same  <= ctlb3_reg.same;
            fdd_reg[0].upd_l <= ctlb3_reg.upd_l;
            fdd_reg[0].upd_r <= ctlb3_reg.upd_r;
            fdd_reg[0].ovf   <= ovf;
            fdd_reg[0].sz    <= (sb3_reg == '0);
            for (int k = 1; k < FD_N; k++)
            begin
                fdd_reg[k] <= fdd_reg[k-1];
            end
        end
    end

    // output stage: sign, clip and flags
    logic [gsk_pkg::OUT_DATA_W-1:0] data_next;
    logic [1:0]                     user_next;
    logic [gsk_pkg::OUT_DATA_W-1:0] data_reg;
    logic [1:0]                     user_reg;

    always_comb
    begin
        gsk_pkg::fd_bundle_t fb;
        logic                negative;
        logic                upd;
        logic                sat;
        logic [OW-1:0]       limit;
        logic [OW-1:0]       mag;
        fb        = fdd_reg[FD_N-1];
        sat       = 1'b0;
        data_next = '0;
        for (int sd = 0; sd < 2; sd++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                negative = (sd == 0) ? !fb.neg[c] : fb.neg[c];
                upd      = (sd == 0) ? fb.upd_l : fb.upd_r;
                limit    = negative ? gsk_pkg::NEG_LIMIT : gsk_pkg::POS_LIMIT;
                mag      = '0;
                if (!fb.same && upd && !fb.sz)
                begin
                    if (fb.ovf[sd*3+c] || (fquo[sd*3+c] > limit))
                    begin
                        mag = limit;
                        sat = 1'b1;
                    end
                    else
                    begin
                        mag = fquo[sd*3+c];
                    end
                end
                data_next[(sd*3+c)*OW +: OW] = negative ? (OW'(0) - mag) : mag;
            end
        end
        user_next = {sat, fb.same};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign m_axis_tdata = data_reg;
    assign m_axis_tuser = user_reg;

endmodule

### tb/sv/softened_gravity_pair_kernel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softened_gravity_pair_kernel_checker
// watches the config, pair and increment channels, predicts each increment
// word from the accepted pair and the live register copies, and compares in
// order
// ----------------------------------------------------------------------------
module softened_gravity_pair_kernel_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [gsk_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gsk_pkg::REG_W-1:0]        cfg_data,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [255:0]                     s_axis_tdata,
    input  logic [1:0]                       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [gsk_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [1:0]                       m_axis_tuser,
    output int                               errors,
    output int                               outstanding,
    output int                               words_seen,
    output int                               coincident_seen,
    output int                               saturated_seen
);

    typedef struct packed {
        logic [5:0][gsk_pkg::OUT_W-1:0] dv;
        logic                           coincident;
        logic                           saturated;
    } kick_t;

    logic [gsk_pkg::REG_W-1:0] gain_reg;
    logic [gsk_pkg::REG_W-1:0] soft_reg;
    logic [gsk_pkg::REG_W-1:0] scale_reg;
    kick_t                     kick_q[$];

    function automatic logic [63:0] int_sqrt(logic [127:0] v);
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [127:0] sq;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            sq   = {64'd0, cand} * {64'd0, cand};
            if (sq <= v)
                root = cand;
        end
        return root;
    endfunction

    function automatic kick_t predict_kick(logic [255:0] pair, logic [1:0] upd);
        kick_t        k;
        logic [31:0]  bl, br, a;
        logic [2:0]   neg;
        logic [63:0]  prod, mw;
        logic [63:0]  meter[3];
        logic [127:0] q, s, num, quot;
        logic [63:0]  span, gm;
        logic [127:0] unit_v[3];
        logic [31:0]  mass;
        logic [47:0]  lim, mag;
        logic         same, negative;
        k    = '0;
        q    = '0;
        same = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            bl     = pair[32*c +: 32] ^ 32'h8000_0000;
            br     = pair[32*(c+3) +: 32] ^ 32'h8000_0000;
            neg[c] = bl < br;
            a      = neg[c] ? br - bl : bl - br;
            if (a != 0)
                same = 1'b0;
            prod = {32'd0, a} * {32'd0, scale_reg};
            mw   = prod >> gsk_pkg::FRACTION_BITS_DEF;
            meter[c] = (mw > {2'b00, gsk_pkg::METER_MAX}) ? {2'b00, gsk_pkg::METER_MAX} : mw;
            q = q + {64'd0, meter[c]} * {64'd0, meter[c]};
        end
        if (same)
        begin
            k.coincident = 1'b1;
            return k;
        end
        span = int_sqrt(q);
        s    = q + ({96'd0, soft_reg} << gsk_pkg::FRACTION_BITS_DEF);
        for (int c = 0; c < 3; c++)
            unit_v[c] = (span == 0) ? 128'd0
                      : ({64'd0, meter[c]} << 32) / {64'd0, span};
        for (int side = 0; side < 2; side++)
        begin
            if (upd[side])
            begin
                mass = (side == 0) ? pair[224 +: 32] : pair[192 +: 32];
                gm   = {32'd0, gain_reg} * {32'd0, mass};
                for (int c = 0; c < 3; c++)
                begin
                    num  = {64'd0, gm} * unit_v[c];
                    quot = (s == 0) ? 128'd0 : (num / s) >> gsk_pkg::FRACTION_BITS_DEF;
                    negative = (side == 0) ? !neg[c] : neg[c];
                    lim = negative ? gsk_pkg::NEG_LIMIT : gsk_pkg::POS_LIMIT;
                    if (quot > {80'd0, lim})
                    begin
                        mag = lim;
                        k.saturated = 1'b1;
                    end
                    else
                        mag = quot[47:0];
                    k.dv[side*3 + c] = negative ? (48'd0 - mag) : mag;
                end
            end
        end
        return k;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kick_t want;
        kick_t got;
        if (!rst_n)
        begin
            gain_reg        <= gsk_pkg::FORCE_GAIN_RST;
            soft_reg        <= gsk_pkg::SOFTENING_RST;
            scale_reg       <= gsk_pkg::METER_SCALE_RST;
            errors          <= 0;
            outstanding     <= 0;
            words_seen      <= 0;
            coincident_seen <= 0;
            saturated_seen  <= 0;
            kick_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gsk_pkg::CFG_FORCE_GAIN:  gain_reg  <= cfg_data;
                    gsk_pkg::CFG_SOFTENING:   soft_reg  <= cfg_data;
                    gsk_pkg::CFG_METER_SCALE: scale_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                kick_q.push_back(predict_kick(s_axis_tdata, s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.dv         = m_axis_tdata;
                got.coincident = m_axis_tuser[0];
                got.saturated  = m_axis_tuser[1];
                words_seen      <= words_seen + 1;
                coincident_seen <= coincident_seen + got.coincident;
                saturated_seen  <= saturated_seen + got.saturated;
                if (kick_q.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected increment word %h", got);
                end
                else
                begin
                    want = kick_q.pop_front();
                    if (want != got)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                        begin
                            $display("increment mismatch at word %0d", words_seen);
                            for (int f = 0; f < 6; f++)
                                if (want.dv[f] != got.dv[f])
                                    $display("  dv[%0d] expected %h actual %h",
                                             f, want.dv[f], got.dv[f]);
                            $display("  coincident expected %b actual %b",
                                     want.coincident, got.coincident);
                            $display("  saturated expected %b actual %b",
                                     want.saturated, got.saturated);
                        end
                    end
                end
            end
            outstanding <= kick_q.size();
        end
    end

endmodule

### tb/sv/softened_gravity_pair_kernel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softened_gravity_pair_kernel_tb
// regression of the softened gravity pair kernel
// ----------------------------------------------------------------------------
// Drives directed and random body pairs through several register settings
// with varying idle and stall patterns, including a long output hold-off;
// the checker predicts and compares every increment word.
// ----------------------------------------------------------------------------
module softened_gravity_pair_kernel_tb;

    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 200;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [gsk_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [gsk_pkg::REG_W-1:0]       cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [255:0]                    s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [gsk_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]                      m_axis_tuser;

    int errors, outstanding, words_seen, coincident_seen, saturated_seen;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_go = 1'b0;
    int pairs_sent = 0;
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    softened_gravity_pair_kernel DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    softened_gravity_pair_kernel_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .errors(errors), .outstanding(outstanding), .words_seen(words_seen),
        .coincident_seen(coincident_seen), .saturated_seen(saturated_seen)
    );

    // output side stall and long hold-off
    always @(posedge clk)
    begin
        int hold_left;
        bit hold_done;
        if (hold_go && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("softened_gravity_pair_kernel regression: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [gsk_pkg::CFG_INDEX_W-1:0] idx,
                             logic [gsk_pkg::REG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pair(logic [31:0] l[3], logic [31:0] r[3],
                             logic [31:0] lm, logic [31:0] rm, logic [1:0] upd);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rm, lm, r[2], r[1], r[0], l[2], l[1], l[0]};
        s_axis_tuser  <= upd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pairs_sent++;
    endtask

    task automatic send_random_pair();
        logic [31:0] l[3], r[3], lm, rm, offs;
        int kind;
        kind = $urandom_range(0, 9);
        for (int c = 0; c < 3; c++)
        begin
            l[c] = $urandom;
            offs = $urandom_range(0, 32'h000F_FFFF);
            if ($urandom_range(0, 1))
                offs = -offs;
            case (kind)
                6: r[c] = $urandom;
                7: r[c] = l[c];
                8:
                begin
                    l[c] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    r[c] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                9: r[c] = (c == 0) ? l[c] + offs : l[c];
                default: r[c] = l[c] + offs;
            endcase
        end
        lm = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1000);
        rm = $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1000);
        if (lm == 0) lm = 1;
        if (rm == 0) rm = 1;
        send_pair(l, r, lm, rm, 2'($urandom_range(0, 3)));
    endtask

    task automatic send_directed();
        logic [31:0] l[3], r[3];
        l = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000};
        r = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000};
        send_pair(l, r, 32'd5, 32'd7, 2'b11);
        l = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_pair(l, r, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11);
        send_pair(r, l, 32'hFFFF_FFFF, 32'd1, 2'b01);
        send_pair(r, l, 32'd1, 32'hFFFF_FFFF, 2'b10);
        send_pair(r, l, 32'd1, 32'd1, 2'b00);
        l = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
        r = '{32'h0000_0001, 32'h0000_0000, 32'h0000_0000};
        send_pair(l, r, 32'd1000, 32'd1000, 2'b11);
        r = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        send_pair(l, r, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11);
        r = '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000};
        send_pair(l, r, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11);
        send_pair(r, l, 32'd1, 32'd1, 2'b11);
        l = '{32'hFFFF_0000, 32'h0001_0000, 32'h8000_0000};
        r = '{32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000};
        send_pair(l, r, 32'd3, 32'd3, 2'b11);
        l = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
        send_pair(l, l, 32'hFFFF_FFFF, 32'd1, 2'b11);
        for (int i = 0; i < 9; i++)
            send_random_pair();
    endtask

    typedef struct {
        logic [31:0] gain;
        logic [31:0] eps_sq;
        logic [31:0] scale;
    } setting_t;

    initial
    begin
        setting_t plan[9];
        plan[0] = '{32'd1, 32'd0, 32'd65536};
        plan[1] = '{32'hFFFF_FFFF, 32'd0, 32'd65536};
        plan[2] = '{32'h0100_0000, 32'hFFFF_FFFF, 32'd65536};
        plan[3] = '{32'hFFFF_FFFF, 32'h0001_0000, 32'd1};
        plan[4] = '{32'h0000_0000, 32'h0000_1000, 32'hFFFF_FFFF};
        plan[5] = '{32'h0010_0000, 32'd0, 32'hFFFF_FFFF};
        plan[6] = '{32'h1234_5678, 32'd0, 32'd1};
        plan[7] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0100};
        plan[8] = '{32'h0400_0000, 32'h0000_8000, 32'h0002_0000};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        s_axis_tvalid <= 1'b0;
        wait_drained();
        write_reg(gsk_pkg::CFG_FORCE_GAIN, 32'hFFFF_FFFF);
        send_directed();
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 9; ph++)
        begin
            write_reg(gsk_pkg::CFG_FORCE_GAIN, plan[ph].gain);
            write_reg(gsk_pkg::CFG_SOFTENING, plan[ph].eps_sq);
            write_reg(gsk_pkg::CFG_METER_SCALE, plan[ph].scale);
            write_reg(gsk_pkg::CFG_INDEX_W'(3), $urandom);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int i = 0; i < 100; i++)
            begin
                if (ph == 1 && i == 20)
                begin
                    send_idle_pct = 0;
                    hold_go <= 1'b1;
                end
                if (ph == 1 && i == 60)
                begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                    send_idle_pct = 53;
                end
                if (i == 70)
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                send_random_pair();
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        $display("pairs sent %0d, increment words checked %0d", pairs_sent, words_seen);
        $display("coincident words %0d, saturated words %0d, settings 11",
                 coincident_seen, saturated_seen);
        if (errors == 0 && outstanding == 0)
            $display("softened_gravity_pair_kernel regression: pass");
        else
            $display("softened_gravity_pair_kernel regression: fail");
        $finish;
    end

endmodule
